[sv/battery_runtime_estimator_unit_assert.svh]
// Assertion macros for the battery runtime estimator.
`ifndef BATTERY_RUNTIME_ESTIMATOR_UNIT_ASSERT_SVH
`define BATTERY_RUNTIME_ESTIMATOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BRE_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BRE_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[sv/bre_pkg.sv]
// Package with payload types and constants of the battery runtime estimator.
package bre_pkg;
    localparam int unsigned RING_DEPTH_DEF = 8;
    localparam logic [31:0] MAX_AGE_RESET = 32'd259200;
    localparam logic [6:0] PCT_FULL = 7'd100;
    localparam logic [6:0] PCT_NINETY = 7'd90;
    localparam logic [6:0] PCT_STEP = 7'd10;

    typedef struct packed {
        logic [6:0]  level_pct;
        logic        charging;
        logic        plugged;
        logic [31:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [31:0] estimate_seconds;
        logic        runtime_valid;
        logic [31:0] runtime_seconds;
        logic        persist_request;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [5:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage

[sv/bre_divider.sv]
// Bit-serial unsigned divider of a 32-bit value by a small divisor.
module bre_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  bre_pkg::div_req_t req,
    output bre_pkg::div_rsp_t rsp
);
    logic [31:0] quot_reg;
    logic [5:0]  rem_reg;
    logic [5:0]  dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  trial;

    assign trial = {rem_reg, quot_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg  <= 6'(trial - {1'b0, dvs_reg});
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[5:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quot_reg;
endmodule

[sv/battery_runtime_estimator_unit.sv]
// Top level of the battery runtime estimator.
// Each status request is latched first and is applied to the scalar state and
// the ring memory in the next cycle. The median is then found by a rank search
// through the ring memory: each candidate entry is compared against every
// entry, and the search stops at the first candidate whose rank range covers
// the middle position, so between one and RING_DEPTH candidates are tried.
// The product of the median and RING_DEPTH is formed next, the bit-serial
// divider divides it (or its sum with the time since the last full charge),
// and a last step forms the estimate and loads the output register. The next
// request is taken only after the result is loaded, so the unit does not
// accept a new request while one is still in flight.
// A result waiting in the output register does not hold back the next
// request; only the final load of the following result waits until the
// register has been emptied. The ring is cleared by a pass over all entries
// after reset, during which no request is taken; configuration writes
// are taken at any time but are meant for periods with nothing in flight.
`include "battery_runtime_estimator_unit_assert.svh"
module battery_runtime_estimator_unit
#(
    parameter int unsigned RING_DEPTH = bre_pkg::RING_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  bre_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bre_pkg::out_item_t  out_data
);
    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(RING_DEPTH);
    localparam logic [AW:0] MID_C = (AW + 1)'(RING_DEPTH / 2);
    localparam logic [AW:0] ONE_C = (AW + 1)'(1);

    typedef enum logic [2:0]
    {
        ST_CLEAR, ST_IDLE, ST_OUTER, ST_INNER, ST_MUL, ST_DIV, ST_FIN
    } state_t;

    state_t        state_reg;
    logic [31:0]   ring_mem [RING_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [31:0]   max_age_reg;
    logic [AW-1:0] head_reg;
    logic [6:0]    last_pct_reg;
    logic          last_chg_reg;
    logic          last_plg_reg;
    logic [31:0]   last_time_reg;
    logic [31:0]   full_time_reg;
    logic          full_valid_reg;

    bre_pkg::in_item_t req_reg;
    logic          persist_reg;
    logic [AW:0]   i_reg;
    logic [AW:0]   j_reg;
    logic [31:0]   cand_reg;
    logic [AW:0]   less_reg;
    logic [AW:0]   leq_reg;
    logic [AW:0]   less_next;
    logic [AW:0]   leq_next;
    logic [31:0]   median_reg;
    logic [31:0]   prod_reg;
    logic [3:0]    rem_tenths_reg;
    bre_pkg::out_item_t out_reg;
    logic          out_valid_reg;
    logic          div_start_reg;
    bre_pkg::div_req_t div_req;
    bre_pkg::div_rsp_t div_rsp;

    // Update step: set when a request has been latched and not yet applied.
    logic pend_reg;
    // The first inner cycle carries the candidate read, not a comparison.
    logic cand_first_reg;

    // Decisions of the update step, taken from the latched request.
    logic [31:0] elapsed;
    logic        store;
    logic        full_set;
    logic        changed;
    logic [6:0]  new_pct;
    logic [3:0]  remaining;
    logic        blend;
    logic [31:0] since;

    assign elapsed = req_reg.now_seconds - last_time_reg;
    assign store = !req_reg.charging && !last_chg_reg && !req_reg.plugged
        && !last_plg_reg && (req_reg.level_pct != bre_pkg::PCT_NINETY)
        && (last_pct_reg >= bre_pkg::PCT_STEP)
        && (req_reg.level_pct == last_pct_reg - bre_pkg::PCT_STEP)
        && (elapsed < max_age_reg);
    assign full_set = last_plg_reg && (last_pct_reg == bre_pkg::PCT_FULL)
        && !last_chg_reg && !req_reg.plugged
        && (req_reg.level_pct == bre_pkg::PCT_FULL);
    assign changed = (req_reg.level_pct != last_pct_reg)
        || (req_reg.charging != last_chg_reg)
        || (req_reg.plugged != last_plg_reg);
    assign new_pct = changed ? req_reg.level_pct : last_pct_reg;
    // Percent is at most 127, so multiplying by 205/2048 gives the exact tenths.
    assign remaining = 4'((16'(new_pct) * 16'd205) >> 11);
    assign blend = full_valid_reg && (rem_tenths_reg <= 4'd9);
    assign since = req_reg.now_seconds - full_time_reg;

    // Rank counters including the entry being compared this cycle.
    assign less_next = (rd_data_reg < cand_reg) ? less_reg + ONE_C : less_reg;
    assign leq_next = (rd_data_reg <= cand_reg) ? leq_reg + ONE_C : leq_reg;

    logic [AW-1:0] head_inc;
    assign head_inc = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // The memory is read at the rank search counters only.
    assign rd_addr = (state_reg == ST_OUTER) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = head_inc;
        wr_data = elapsed;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0];
                wr_data = '0;
            end
            ST_IDLE:
            begin
                wr_en = pend_reg && store;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    assign div_req.start = div_start_reg;
    assign div_req.dividend = blend ? prod_reg + since : prod_reg;
    assign div_req.divisor = blend ? 6'(RING_DEPTH + 10 - 32'(rem_tenths_reg))
                                   : 6'(RING_DEPTH);

    bre_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            max_age_reg    <= bre_pkg::MAX_AGE_RESET;
            head_reg       <= '0;
            last_pct_reg   <= '0;
            last_chg_reg   <= 1'b0;
            last_plg_reg   <= 1'b0;
            last_time_reg  <= '0;
            full_time_reg  <= '0;
            full_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            req_reg        <= '0;
            persist_reg    <= 1'b0;
            cand_reg       <= '0;
            less_reg       <= '0;
            leq_reg        <= '0;
            median_reg     <= '0;
            prod_reg       <= '0;
            rem_tenths_reg <= '0;
            out_reg        <= '0;
        end
        else
        begin
            div_start_reg <= (state_reg == ST_MUL);
            if (cfg_we)
            begin
                max_age_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    i_reg <= i_reg + ONE_C;
                    if (i_reg == DEPTH_C - ONE_C)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pend_reg)
                    begin
                        // Apply the state update; the ring write happens here too.
                        pend_reg <= 1'b0;
                        if (store)
                        begin
                            head_reg <= head_inc;
                        end
                        if (full_set)
                        begin
                            full_time_reg  <= req_reg.now_seconds;
                            full_valid_reg <= 1'b1;
                        end
                        else if (req_reg.plugged)
                        begin
                            full_valid_reg <= 1'b0;
                        end
                        if (changed)
                        begin
                            last_pct_reg  <= req_reg.level_pct;
                            last_chg_reg  <= req_reg.charging;
                            last_plg_reg  <= req_reg.plugged;
                            last_time_reg <= req_reg.now_seconds;
                        end
                        rem_tenths_reg <= remaining;
                        persist_reg <= store || full_set || req_reg.plugged || changed;
                        i_reg <= '0;
                        state_reg <= ST_OUTER;
                    end
                    else if (in_valid && !in_stall)
                    begin
                        req_reg  <= in_data;
                        pend_reg <= 1'b1;
                    end
                end
                ST_OUTER:
                begin
                    // Read of entry i issued this cycle; it is the candidate.
                    j_reg    <= '0;
                    less_reg <= '0;
                    leq_reg  <= '0;
                    state_reg <= ST_INNER;
                end
                ST_INNER:
                begin
                    // Cycle with j == 0 latches the candidate and reads entry 0.
                    if (j_reg == '0 && cand_first_reg)
                    begin
                        cand_reg <= rd_data_reg;
                    end
                    else
                    begin
                        less_reg <= less_next;
                        leq_reg  <= leq_next;
                    end
                    if (j_reg == DEPTH_C)
                    begin
                        // Candidate is the median when its rank range spans MID.
                        if (less_next <= MID_C && leq_next > MID_C)
                        begin
                            median_reg <= cand_reg;
                            state_reg  <= ST_MUL;
                        end
                        else
                        begin
                            i_reg     <= i_reg + ONE_C;
                            state_reg <= ST_OUTER;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + ONE_C;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= median_reg * 32'(RING_DEPTH);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    // The quotient and the operands hold, so the load can wait.
                    if (!out_valid_reg)
                    begin
                        out_reg.estimate_seconds <=
                            32'(div_rsp.quotient * 32'(rem_tenths_reg));
                        out_reg.runtime_valid    <= full_valid_reg;
                        out_reg.runtime_seconds  <= full_valid_reg ? since : '0;
                        out_reg.persist_request  <= persist_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_first_reg <= 1'b0;
        end
        else
        begin
            cand_first_reg <= (state_reg == ST_OUTER);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE) || pend_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `BRE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `BRE_ASSERT_IMP(a_runtime_zero, clk, rst_n, out_valid && !out_data.runtime_valid,
        out_data.runtime_seconds == '0)
    `BRE_ASSERT_NXT(a_accept_pends, clk, rst_n, in_valid && !in_stall, pend_reg)
endmodule
